### src/discrete_frechet_distance_macros.svh
// Assertion macros used by the checker file of the discrete Frechet block.
// No dependencies; the includer provides the clock and reset nets.
`ifndef DISCRETE_FRECHET_DISTANCE_MACROS_SVH
`define DISCRETE_FRECHET_DISTANCE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DFD_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dfd check failed");

// Check a property on every clock edge, reset included.
`define DFD_CHECK_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("dfd check failed during reset");

`endif

### src/dfd_pkg.sv
// Types, widths and codes for the discrete Frechet distance block.
// No dependencies; used by every module of the block except dfd_ram.
`default_nettype none

package dfd_pkg;

   localparam int COORD_BITS         = 16;
   localparam int MAG_BITS           = COORD_BITS;
   localparam int SQ_BITS            = 2 * COORD_BITS;
   localparam int DSQ_BITS           = SQ_BITS + 1;
   localparam int DIST_BITS          = 17;
   localparam int STATUS_BITS        = 2;
   localparam int MAX_POINTS_DEFAULT = 1024;

   localparam logic OP_REF   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_TRUNC = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_CELL,
      ST_EMIT
   } state_type;

   // Controls for the squared distance unit, one step per cycle.
   typedef struct packed {
      logic cap_diff;
      logic sq_x;
      logic sq_y;
   } sq_ctrl_type;

endpackage

`default_nettype wire

### src/dfd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module dfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/dfd_sqdist.sv
// Squared Euclidean distance unit with one shared multiplier used twice.
// Depends on dfd_pkg for widths and the control struct.
`default_nettype none

module dfd_sqdist (
   input  wire logic                                  clock,
   input  wire dfd_pkg::sq_ctrl_type                  ctrl,
   input  wire logic signed [dfd_pkg::COORD_BITS-1:0] qx,
   input  wire logic signed [dfd_pkg::COORD_BITS-1:0] qy,
   input  wire logic signed [dfd_pkg::COORD_BITS-1:0] rx,
   input  wire logic signed [dfd_pkg::COORD_BITS-1:0] ry,
   output logic             [dfd_pkg::DSQ_BITS-1:0]   dsq
);

   import dfd_pkg::*;

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic        [COORD_BITS:0] dx_abs;
   logic        [COORD_BITS:0] dy_abs;
   logic [MAG_BITS-1:0]        mag_x_ff;
   logic [MAG_BITS-1:0]        mag_y_ff;
   logic [MAG_BITS-1:0]        mul_op;
   logic [SQ_BITS-1:0]         product;
   logic [SQ_BITS-1:0]         sq_x_ff;
   logic [SQ_BITS-1:0]         sq_y_ff;

   always_comb begin
      dx     = {qx[COORD_BITS-1], qx} - {rx[COORD_BITS-1], rx};
      dy     = {qy[COORD_BITS-1], qy} - {ry[COORD_BITS-1], ry};
      dx_abs = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
      dy_abs = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);
      // x goes through the multiplier first, then y
      mul_op  = ctrl.sq_y ? mag_y_ff : mag_x_ff;
      product = mul_op * mul_op;
      dsq     = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   end

   always_ff @(posedge clock) begin
      if (ctrl.cap_diff) begin
         mag_x_ff <= dx_abs[MAG_BITS-1:0];
         mag_y_ff <= dy_abs[MAG_BITS-1:0];
      end
      if (ctrl.sq_x) begin
         sq_x_ff <= product;
      end
      if (ctrl.sq_y) begin
         sq_y_ff <= product;
      end
   end

endmodule

`default_nettype wire

### src/dfd_isqrt.sv
// Floored integer square root, two radicand bits per cycle.
// Depends on dfd_pkg for the operand and root widths.
`default_nettype none

module dfd_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dfd_pkg::DSQ_BITS-1:0]  value,
   output logic                               busy,
   output logic      [dfd_pkg::DIST_BITS-1:0] root
);

   import dfd_pkg::*;

   localparam int VAL_BITS = 2 * DIST_BITS;
   localparam int REM_BITS = DIST_BITS + 1;
   localparam int CNT_BITS = $clog2(DIST_BITS);

   logic                busy_ff,  busy_in;
   logic [CNT_BITS-1:0] cnt_ff,   cnt_in;
   logic [VAL_BITS-1:0] val_ff,   val_in;
   logic [REM_BITS-1:0] rem_ff,   rem_in;
   logic [DIST_BITS-1:0] root_ff, root_in;
   logic [REM_BITS+1:0] rem_sh;
   logic [REM_BITS+1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, val_ff[VAL_BITS-1 -: 2]};
      trial   = (REM_BITS + 2)'({root_ff, 2'b01});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIST_BITS - 1);
         val_in  = VAL_BITS'(value);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[VAL_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_BITS'(rem_sh - trial);
            root_in = {root_ff[DIST_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_BITS-1:0];
            root_in = {root_ff[DIST_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

### src/discrete_frechet_distance.sv
// Top level of the discrete Frechet distance block: sequencer, DP cell, stores.
// Depends on dfd_pkg, dfd_ram, dfd_sqdist and dfd_isqrt.
//
//  channel  dir  handshake                data
//  req      in   req_tvalid/req_tready    tdata x,y; tuser operation; tlast last
//  rsp      out  rsp_tvalid/rsp_tready    tdata dist_sq,dist; tuser status
//
// A reference point is stored straight from the idle state. A query point
// runs DIFF, SQX, SQY and CELL for each stored point: the shared multiplier
// squares dx then dy. A closing query point then waits for the square root unit.
// Reset is synchronous; the stores need no clearing after it.
// The result sits in an output register; a stalled result only blocks the
// next closing query point from delivering its own.
`default_nettype none

module discrete_frechet_distance #(
   parameter int MAX_POINTS = dfd_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [2*dfd_pkg::COORD_BITS-1:0] req_tdata, // x_coord, y_coord
   input  wire logic                             req_tuser, // operation
   input  wire logic                             req_tlast, // last
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [55:0]                           rsp_tdata, // distance_squared, distance
   output logic [dfd_pkg::STATUS_BITS-1:0]       rsp_tuser  // status
);

   import dfd_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PT_BITS = 2 * COORD_BITS;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    closed_ff, closed_in;
   logic                    trunc_ff, trunc_in;
   logic                    first_ff, first_in;
   logic [CW-1:0]           j_ff, j_in;
   logic signed [COORD_BITS-1:0] qx_ff, qx_in;
   logic signed [COORD_BITS-1:0] qy_ff, qy_in;
   logic                    qlast_ff, qlast_in;
   logic [DSQ_BITS-1:0]     diag_ff, diag_in;
   logic [DSQ_BITS-1:0]     left_ff, left_in;
   logic [DSQ_BITS-1:0]     up_ff, up_in;
   logic [DSQ_BITS-1:0]     res_dsq_ff, res_dsq_in;
   logic [STATUS_BITS-1:0]  res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DSQ_BITS-1:0]     rsp_dsq_ff, rsp_dsq_in;
   logic [DIST_BITS-1:0]    rsp_dist_ff, rsp_dist_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;

   logic                    req_xfer;
   logic [CW-1:0]           eff_count;
   logic [CW-1:0]           j_next;
   logic                    pt_wr_en;
   logic [PT_BITS-1:0]      pt_rdata;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    row_wr_en;
   logic [DSQ_BITS-1:0]     row_rdata;
   logic [DSQ_BITS-1:0]     dsq;
   logic [DSQ_BITS-1:0]     min_ud;
   logic [DSQ_BITS-1:0]     min3;
   logic [DSQ_BITS-1:0]     base;
   logic [DSQ_BITS-1:0]     dp_cell;
   logic                    sq_start;
   logic [DSQ_BITS-1:0]     sq_value;
   logic                    sq_busy;
   logic [DIST_BITS-1:0]    sq_root;
   sq_ctrl_type             sd_ctrl;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign eff_count  = closed_ff ? '0 : count_ff;
   assign j_next     = j_ff + CW'(1);

   // DP cell: the first row only looks left, the first column only up
   always_comb begin
      min_ud = (up_ff < diag_ff) ? up_ff : diag_ff;
      min3   = (min_ud < left_ff) ? min_ud : left_ff;
      if (first_ff) begin
         base = (j_ff == '0) ? '0 : left_ff;
      end else begin
         base = (j_ff == '0) ? up_ff : min3;
      end
      dp_cell = (dsq > base) ? dsq : base;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      closed_in     = closed_ff;
      trunc_in      = trunc_ff;
      first_in      = first_ff;
      j_in          = j_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      qlast_in      = qlast_ff;
      diag_in       = diag_ff;
      left_in       = left_ff;
      up_in         = up_ff;
      res_dsq_in    = res_dsq_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_dsq_in    = rsp_dsq_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      pt_wr_en      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      row_wr_en     = 1'b0;
      sq_start      = 1'b0;
      sq_value      = '0;
      sd_ctrl       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_tuser == OP_REF)) begin
               closed_in = req_tlast;
               first_in  = 1'b1;
               if (eff_count < CW'(MAX_POINTS)) begin
                  pt_wr_en = 1'b1;
                  count_in = eff_count + CW'(1);
                  trunc_in = closed_ff ? 1'b0 : trunc_ff;
               end else begin
                  count_in = eff_count;
                  trunc_in = 1'b1;
               end
            end else if (req_xfer) begin
               closed_in = 1'b1;
               qx_in     = $signed(req_tdata[COORD_BITS-1:0]);
               qy_in     = $signed(req_tdata[PT_BITS-1:COORD_BITS]);
               qlast_in  = req_tlast;
               if (count_ff == '0) begin
                  if (req_tlast) begin
                     first_in      = 1'b1;
                     res_dsq_in    = '0;
                     res_status_in = STATUS_EMPTY;
                     sq_start      = 1'b1;
                     state_in      = ST_EMIT;
                  end
               end else begin
                  // fetch the first stored point and its column
                  rd_en    = 1'b1;
                  j_in     = '0;
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            sd_ctrl.cap_diff = 1'b1;
            up_in            = row_rdata;
            state_in         = ST_SQX;
         end
         ST_SQX: begin
            sd_ctrl.sq_x = 1'b1;
            state_in     = ST_SQY;
         end
         ST_SQY: begin
            sd_ctrl.sq_y = 1'b1;
            // prefetch the next column while this cell finishes
            rd_en        = 1'b1;
            rd_addr      = j_next[AW-1:0];
            state_in     = ST_CELL;
         end
         ST_CELL: begin
            row_wr_en = 1'b1;
            diag_in   = up_ff;
            left_in   = dp_cell;
            if (j_next == count_ff) begin
               first_in = 1'b0;
               state_in = ST_IDLE;
               if (qlast_ff) begin
                  first_in      = 1'b1;
                  res_dsq_in    = dp_cell;
                  res_status_in = trunc_ff ? STATUS_TRUNC : STATUS_OK;
                  sq_start      = 1'b1;
                  sq_value      = dp_cell;
                  state_in      = ST_EMIT;
               end
            end else begin
               j_in     = j_next;
               state_in = ST_DIFF;
            end
         end
         ST_EMIT: begin
            if (!sq_busy && (!rsp_valid_ff || rsp_tready)) begin
               rsp_valid_in  = 1'b1;
               rsp_dsq_in    = res_dsq_ff;
               rsp_dist_in   = sq_root;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         closed_ff    <= 1'b1;
         trunc_ff     <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         trunc_ff     <= trunc_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff          <= j_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      qlast_ff      <= qlast_in;
      diag_ff       <= diag_in;
      left_ff       <= left_in;
      up_ff         <= up_in;
      res_dsq_ff    <= res_dsq_in;
      res_status_ff <= res_status_in;
      rsp_dsq_ff    <= rsp_dsq_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   dfd_ram #(
      .WIDTH(PT_BITS),
      .DEPTH(MAX_POINTS)
   ) u_point_ram (
      .clock  (clock),
      .wr_en  (pt_wr_en),
      .wr_addr(eff_count[AW-1:0]),
      .wr_data(req_tdata),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(pt_rdata)
   );

   dfd_ram #(
      .WIDTH(DSQ_BITS),
      .DEPTH(MAX_POINTS)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (row_wr_en),
      .wr_addr(j_ff[AW-1:0]),
      .wr_data(dp_cell),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(row_rdata)
   );

   dfd_sqdist u_sqdist (
      .clock(clock),
      .ctrl (sd_ctrl),
      .qx   (qx_ff),
      .qy   (qy_ff),
      .rx   ($signed(pt_rdata[COORD_BITS-1:0])),
      .ry   ($signed(pt_rdata[PT_BITS-1:COORD_BITS])),
      .dsq  (dsq)
   );

   dfd_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .start(sq_start),
      .value(sq_value),
      .busy (sq_busy),
      .root (sq_root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 56'({rsp_dist_ff, rsp_dsq_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

### src/dfd_checker.sv
// Port-level checker for the discrete Frechet distance block, bound to the top.
// Depends on dfd_pkg and discrete_frechet_distance_macros.svh.
`default_nettype none

`include "discrete_frechet_distance_macros.svh"

module dfd_port_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [55:0]                      rsp_tdata,
   input wire logic [dfd_pkg::STATUS_BITS-1:0]  rsp_tuser
);

   import dfd_pkg::*;

   logic ref_xfer;
   logic rsp_stall;

   assign ref_xfer  = req_tvalid && req_tready && (req_tuser == OP_REF);
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // a stalled result holds
   `DFD_CHECK(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable({rsp_tdata, rsp_tuser}))
   // a reference point is stored and the block is ready again in the next cycle
   `DFD_CHECK(a_ref_single_cycle, ref_xfer |=> req_tready)
   // a reference point never produces a result
   `DFD_CHECK(a_ref_no_result, ref_xfer |=> !$rose(rsp_tvalid))
   // reset leaves the block idle with nothing to deliver
   `DFD_CHECK_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid && req_tready)

endmodule

bind discrete_frechet_distance dfd_port_checker u_dfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
